/* src/wav_riff_stream_parser_defines.svh */
// ----------------------------------------------------------------------------
// wav riff stream parser assertion macros
// property check helpers shared by the parser rtl
// ----------------------------------------------------------------------------
`ifndef WAV_RIFF_STREAM_PARSER_DEFINES_SVH
`define WAV_RIFF_STREAM_PARSER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define WRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrp same-cycle check failed");
// next-cycle implication
`define WRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrp next-cycle check failed");
`else
`define WRP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define WRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/wrp_pkg.sv */
// ----------------------------------------------------------------------------
// wrp_pkg
// types and constants of the wav riff stream parser
// ----------------------------------------------------------------------------
package wrp_pkg;

    // parse phase, one-hot
    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_CHUNK  = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SHORT     = 3'd1;
    localparam logic [2:0] ERR_MAGIC     = 3'd2;
    localparam logic [2:0] ERR_CHANNELS  = 3'd3;
    localparam logic [2:0] ERR_NO_DATA   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;

    // header layout
    localparam logic [5:0] HDR_LAST_POS  = 6'd35;
    localparam logic [5:0] POS_CHAN_LO   = 6'd22;
    localparam logic [5:0] POS_CHAN_HI   = 6'd23;
    localparam logic [5:0] POS_RATE_LO   = 6'd24;
    localparam logic [5:0] POS_RATE_END  = 6'd28;
    localparam logic [5:0] POS_WAVE_LO   = 6'd8;
    localparam logic [5:0] POS_WAVE_END  = 6'd16;
    localparam logic [5:0] POS_RIFF_END  = 6'd4;
    localparam logic [5:0] POS_BITS_LO   = 6'd34;

    localparam logic [7:0]  RIFF_MAGIC [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0]  WAVE_MAGIC [8] = '{8'h57, 8'h41, 8'h56, 8'h45,
                                               8'h66, 8'h6D, 8'h74, 8'h20};
    localparam logic [31:0] DATA_ID        = 32'h64617461;
    localparam logic [15:0] BITS_16        = 16'd16;

endpackage

/* src/wav_riff_stream_parser.sv */
// a result beat is valid in the cycle after the byte beat that causes it
// throughput: one byte beat per cycle while the master side keeps tready high
// s_tready follows m_tready while the output register holds a result, else stays high
// reset (i_rst_n low, synchronous) returns the parser to the header phase and empties
// the output register; every beat with tlast also returns the parse state to reset
// ----------------------------------------------------------------------------
// wav_riff_stream_parser
// checks a riff/wave pcm header, finds the data chunk, reports format and
// passes the payload bytes through
// ----------------------------------------------------------------------------
`include "wav_riff_stream_parser_defines.svh"

module wav_riff_stream_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte side
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // file_byte
    input  logic         i_s_tlast,   // buffer_end
    // result side
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // data_value[7:0], channel_count[9:8], sample_rate[41:10], sample_bits[57:42],
    // payload_length[89:58], last_sample_index[122:90], error_code[125:123], zero
    output logic [127:0] o_m_tdata,
    output logic [1:0]   o_m_tuser,   // result_kind
    output logic         o_m_tlast    // run_last
);

    // parse state
    wrp_pkg::t_phase r_phase, n_phase;
    logic [5:0]      r_pos,   n_pos;
    logic [31:0]     r_shift, n_shift;
    logic [15:0]     r_chan,  n_chan;
    logic [31:0]     r_rate,  n_rate;
    logic [15:0]     r_bits,  n_bits;
    logic [2:0]      r_fault, n_fault;
    logic [31:0]     r_rem,   n_rem;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_kind;
    logic [7:0]         r_data;
    logic [1:0]         r_chan_out;
    logic [31:0]        r_rate_out;
    logic [15:0]        r_bits_out;
    logic [31:0]        r_len;
    logic signed [32:0] r_idx;
    logic [2:0]         r_err;
    logic               r_last;

    // result of the current beat
    logic               res_valid;
    logic [1:0]         res_kind;
    logic [7:0]         res_data;
    logic [1:0]         res_chan;
    logic [31:0]        res_rate;
    logic [15:0]        res_bits;
    logic [31:0]        res_len;
    logic signed [32:0] res_idx;
    logic [2:0]         res_err;
    logic               res_last;

    logic       in_acc;
    logic [2:0] chunk_pos;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign chunk_pos  = r_pos[2:0];

    // next state and result for one byte beat
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_shift  = r_shift;
        n_chan   = r_chan;
        n_rate   = r_rate;
        n_bits   = r_bits;
        n_fault  = r_fault;
        n_rem    = r_rem;
        res_valid = 1'b0;
        res_kind  = wrp_pkg::KIND_DATA;
        res_data  = 8'd0;
        res_chan  = 2'd0;
        res_rate  = 32'd0;
        res_bits  = 16'd0;
        res_len   = 32'd0;
        res_idx   = 33'sd0;
        res_err   = wrp_pkg::ERR_NONE;
        res_last  = 1'b0;

        case (r_phase)
            wrp_pkg::PH_HEADER: begin
                // field capture and magic checks
                if (r_pos < wrp_pkg::POS_RIFF_END) begin
                    if (i_s_tdata != wrp_pkg::RIFF_MAGIC[r_pos[1:0]] &&
                        r_fault == wrp_pkg::ERR_NONE) begin
                        n_fault = wrp_pkg::ERR_MAGIC;
                    end
                end else if (r_pos >= wrp_pkg::POS_WAVE_LO && r_pos < wrp_pkg::POS_WAVE_END) begin
                    if (i_s_tdata != wrp_pkg::WAVE_MAGIC[r_pos[2:0]] &&
                        r_fault == wrp_pkg::ERR_NONE) begin
                        n_fault = wrp_pkg::ERR_MAGIC;
                    end
                end else if (r_pos == wrp_pkg::POS_CHAN_LO) begin
                    n_chan = {8'd0, i_s_tdata};
                end else if (r_pos == wrp_pkg::POS_CHAN_HI) begin
                    n_chan = {i_s_tdata, r_chan[7:0]};
                    if (n_chan != 16'd1 && n_chan != 16'd2 &&
                        r_fault == wrp_pkg::ERR_NONE) begin
                        n_fault = wrp_pkg::ERR_CHANNELS;
                    end
                end else if (r_pos >= wrp_pkg::POS_RATE_LO && r_pos < wrp_pkg::POS_RATE_END) begin
                    n_rate[{r_pos[1:0], 3'b000} +: 8] = i_s_tdata;
                end else if (r_pos == wrp_pkg::POS_BITS_LO) begin
                    n_bits = {8'd0, i_s_tdata};
                end else if (r_pos == wrp_pkg::HDR_LAST_POS) begin
                    n_bits = {i_s_tdata, r_bits[7:0]};
                end

                // header end or short buffer
                if (r_pos == wrp_pkg::HDR_LAST_POS) begin
                    n_pos = 6'd0;
                    if (n_fault != wrp_pkg::ERR_NONE) begin
                        res_valid = 1'b1;
                        res_kind  = wrp_pkg::KIND_ERROR;
                        res_err   = n_fault;
                        res_last  = 1'b1;
                        n_phase   = wrp_pkg::PH_DONE;
                    end else if (i_s_tlast) begin
                        res_valid = 1'b1;
                        res_kind  = wrp_pkg::KIND_ERROR;
                        res_err   = wrp_pkg::ERR_NO_DATA;
                        res_last  = 1'b1;
                    end else begin
                        n_phase = wrp_pkg::PH_CHUNK;
                        n_shift = 32'd0;
                        n_rem   = 32'd0;
                    end
                end else begin
                    n_pos = r_pos + 6'd1;
                    if (i_s_tlast) begin
                        res_valid = 1'b1;
                        res_kind  = wrp_pkg::KIND_ERROR;
                        res_err   = wrp_pkg::ERR_SHORT;
                        res_last  = 1'b1;
                    end
                end
            end

            wrp_pkg::PH_CHUNK: begin
                // id bytes shift in, length bytes little endian
                if (!chunk_pos[2]) begin
                    n_shift = {r_shift[23:0], i_s_tdata};
                end else begin
                    n_rem[{chunk_pos[1:0], 3'b000} +: 8] = i_s_tdata;
                end

                if (chunk_pos == 3'd7) begin
                    n_pos = 6'd0;
                    if (n_shift == wrp_pkg::DATA_ID) begin
                        if (i_s_tlast && n_rem != 32'd0) begin
                            res_valid = 1'b1;
                            res_kind  = wrp_pkg::KIND_ERROR;
                            res_err   = wrp_pkg::ERR_TRUNCATED;
                            res_last  = 1'b1;
                        end else begin
                            // format report
                            res_valid = 1'b1;
                            res_kind  = wrp_pkg::KIND_REPORT;
                            res_chan  = r_chan[1:0];
                            res_rate  = r_rate;
                            res_bits  = r_bits;
                            res_len   = n_rem;
                            res_idx   = (r_bits == wrp_pkg::BITS_16) ?
                                        $signed({2'b00, n_rem[31:1]} - 33'd1) :
                                        $signed({1'b0, n_rem} - 33'd1);
                            res_last  = (n_rem == 32'd0);
                            n_phase   = (n_rem == 32'd0) ? wrp_pkg::PH_DONE : wrp_pkg::PH_DATA;
                        end
                    end else if (i_s_tlast) begin
                        res_valid = 1'b1;
                        res_kind  = wrp_pkg::KIND_ERROR;
                        res_err   = wrp_pkg::ERR_NO_DATA;
                        res_last  = 1'b1;
                    end else begin
                        n_phase = (n_rem == 32'd0) ? wrp_pkg::PH_CHUNK : wrp_pkg::PH_SKIP;
                        n_shift = 32'd0;
                    end
                end else begin
                    n_pos = r_pos + 6'd1;
                    if (i_s_tlast) begin
                        res_valid = 1'b1;
                        res_kind  = wrp_pkg::KIND_ERROR;
                        res_err   = wrp_pkg::ERR_NO_DATA;
                        res_last  = 1'b1;
                    end
                end
            end

            wrp_pkg::PH_SKIP: begin
                // skip an unwanted chunk body
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    n_phase = wrp_pkg::PH_CHUNK;
                    n_pos   = 6'd0;
                    n_shift = 32'd0;
                end
                if (i_s_tlast) begin
                    res_valid = 1'b1;
                    res_kind  = wrp_pkg::KIND_ERROR;
                    res_err   = wrp_pkg::ERR_NO_DATA;
                    res_last  = 1'b1;
                end
            end

            wrp_pkg::PH_DATA: begin
                // payload pass-through
                n_rem     = r_rem - 32'd1;
                res_valid = 1'b1;
                res_data  = i_s_tdata;
                if (n_rem == 32'd0) begin
                    res_last = 1'b1;
                    n_phase  = wrp_pkg::PH_DONE;
                end else if (i_s_tlast) begin
                    res_kind = wrp_pkg::KIND_ERROR;
                    res_err  = wrp_pkg::ERR_TRUNCATED;
                    res_last = 1'b1;
                end
            end

            default: begin
            end
        endcase

        // end of buffer starts a fresh run
        if (i_s_tlast) begin
            n_phase = wrp_pkg::PH_HEADER;
            n_pos   = 6'd0;
            n_shift = 32'd0;
            n_chan  = 16'd0;
            n_rate  = 32'd0;
            n_bits  = 16'd0;
            n_fault = wrp_pkg::ERR_NONE;
            n_rem   = 32'd0;
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wrp_pkg::PH_HEADER;
            r_pos   <= 6'd0;
            r_shift <= 32'd0;
            r_chan  <= 16'd0;
            r_rate  <= 32'd0;
            r_bits  <= 16'd0;
            r_fault <= wrp_pkg::ERR_NONE;
            r_rem   <= 32'd0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_bits  <= n_bits;
            r_fault <= n_fault;
            r_rem   <= n_rem;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_kind     <= res_kind;
            r_data     <= res_data;
            r_chan_out <= res_chan;
            r_rate_out <= res_rate;
            r_bits_out <= res_bits;
            r_len      <= res_len;
            r_idx      <= res_idx;
            r_err      <= res_err;
            r_last     <= res_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {2'b00, r_err, r_idx, r_len, r_bits_out, r_rate_out,
                         r_chan_out, r_data};

    // checks
    `WRP_ASSERT_NEXT(a_tlast_restarts, i_clk, i_rst_n, in_acc && i_s_tlast,
        r_phase == wrp_pkg::PH_HEADER && r_pos == 6'd0)
    `WRP_ASSERT_NOW(a_data_has_bytes, i_clk, i_rst_n, r_phase == wrp_pkg::PH_DATA,
        r_rem != 32'd0)
    `WRP_ASSERT_NOW(a_error_ends_run, i_clk, i_rst_n,
        r_out_valid && r_kind == wrp_pkg::KIND_ERROR, r_last)
    `WRP_ASSERT_NOW(a_last_report_empty, i_clk, i_rst_n,
        r_out_valid && r_kind == wrp_pkg::KIND_REPORT && r_last, r_len == 32'd0)

endmodule
